// File: rtl/core/sorted_table_engine_assert.svh
// Assertion macros used by the sorted table engine checker.
`ifndef SORTED_TABLE_ENGINE_ASSERT_SVH
`define SORTED_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define STE_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_table_engine: check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define STE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_table_engine: check failed");

`endif

// File: rtl/core/ste_pkg.sv
// Types and codes of the sorted table engine.
package ste_pkg;

   // Widths of the transaction fields
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 5;

   // Action codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_FIND   = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_ERASE  = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   // Shift commands broadcast to every cell
   typedef struct packed {
      logic ins;
      logic del;
   } cell_ctrl_type;

endpackage

// File: rtl/core/ste_if.sv
// Request and response channel interfaces of the sorted table engine.
interface ste_req_if;
   logic                                valid;
   logic                                ready;
   logic        [ste_pkg::ACTION_W-1:0] action;
   logic signed [ste_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface ste_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ste_pkg::STATUS_W-1:0]  status;
   logic [ste_pkg::INDEX_W-1:0]   index;
   logic [ste_pkg::INDEX_W-1:0]   entry_count;

   modport source (output valid, output status, output index, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input index, input entry_count,
                   output ready);
endinterface

// File: rtl/core/ste_cell.sv
// One compare-and-shift cell of the sorted table: holds a single entry.
module ste_cell (
   input  logic                               clock,
   input  logic signed [ste_pkg::VALUE_W-1:0] key,
   input  logic                               valid,
   input  logic                               left_lt,
   input  logic signed [ste_pkg::VALUE_W-1:0] left_entry,
   input  logic signed [ste_pkg::VALUE_W-1:0] right_entry,
   input  ste_pkg::cell_ctrl_type             ctrl,
   output logic                               lt,
   output logic                               pos,
   output logic                               eq,
   output logic signed [ste_pkg::VALUE_W-1:0] entry
);

   logic signed [ste_pkg::VALUE_W-1:0] entry_ff;
   logic signed [ste_pkg::VALUE_W-1:0] entry_in;

   // Compare against the key; stale cells above the count never compare
   assign lt    = valid && (entry_ff < key);
   assign eq    = valid && (entry_ff == key);
   // First cell not less than the key: the lower-bound position
   assign pos   = left_lt && !lt;
   assign entry = entry_ff;

   // Insert: take the key at the position, shift up above it.
   // Erase: from the position up, take the right neighbor.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (pos) begin
            entry_in = key;
         end else if (!left_lt) begin
            entry_in = left_entry;
         end
      end else if (ctrl.del) begin
         if (!lt) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/core/sorted_table_engine.sv
// Sorted table engine: a row of compare-and-shift cells keeping signed values in order.
//
// Usage:
//   req_ch carries one transaction per action: action (find, insert, erase,
//   clear) and a signed 32-bit value. rsp_ch returns one transaction per
//   request: status, index and entry_count after the action.
//   Every cell compares its entry with the value in the same cycle; the first
//   cell that is not less than the value marks the position, and on insert or
//   erase the cells above it take their neighbor's entry on the same edge.
//   The response is registered: it is valid in the cycle after the request is accepted.
//   Throughput is one action per cycle while rsp_ch.ready stays high, set by
//   the single compare-and-shift pass through the cell row and the one-deep
//   response register. req_ch.ready is high while the response register is
//   empty or being taken, so a stalled receiver holds one response and
//   back-pressures the request side after that.
//   Reset clears the entry count and the response valid flag; cell contents
//   are not cleared, since cells above the count are never compared.
//   Inserting into a full table returns status full and leaves it unchanged.
module sorted_table_engine #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   ste_req_if.sink    req_ch,
   ste_rsp_if.source  rsp_ch
);

   localparam int CW = $clog2(DEPTH + 1);

   logic                                 fire;
   ste_pkg::action_type                  action;
   ste_pkg::cell_ctrl_type               ctrl;

   logic [DEPTH-1:0]                     lt;
   logic [DEPTH-1:0]                     pos;
   logic [DEPTH-1:0]                     eq;
   logic [DEPTH-1:0]                     left_lt;
   logic signed [ste_pkg::VALUE_W-1:0]   entry       [DEPTH];
   logic signed [ste_pkg::VALUE_W-1:0]   left_entry  [DEPTH];
   logic signed [ste_pkg::VALUE_W-1:0]   right_entry [DEPTH];

   logic [CW-1:0]                        count_ff;
   logic [CW-1:0]                        count_in;
   logic [CW-1:0]                        pos_idx;
   logic                                 found;
   logic                                 full;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [ste_pkg::STATUS_W-1:0]         status_ff;
   logic [ste_pkg::STATUS_W-1:0]         status_in;
   logic [ste_pkg::INDEX_W-1:0]          index_ff;
   logic [ste_pkg::INDEX_W-1:0]          index_in;

   // Handshake
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;
   assign action       = ste_pkg::action_type'(req_ch.action);

   assign found = |(pos & eq);
   assign full  = (count_ff == CW'(DEPTH));

   // Shift commands to the cell row
   assign ctrl.ins = fire && (action == ste_pkg::ACT_INSERT) && !full;
   assign ctrl.del = fire && (action == ste_pkg::ACT_ERASE) && found;

   // Neighbor wiring; the row ends see constants or themselves
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign left_lt[g]    = 1'b1;
            assign left_entry[g] = entry[g];
         end else begin : g_inner
            assign left_lt[g]    = lt[g-1];
            assign left_entry[g] = entry[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_entry[g] = entry[g];
         end else begin : g_body
            assign right_entry[g] = entry[g+1];
         end

         ste_cell u_cell (
            .clock       (clock),
            .key         (req_ch.value),
            .valid       (CW'(g) < count_ff),
            .left_lt     (left_lt[g]),
            .left_entry  (left_entry[g]),
            .right_entry (right_entry[g]),
            .ctrl        (ctrl),
            .lt          (lt[g]),
            .pos         (pos[g]),
            .eq          (eq[g]),
            .entry       (entry[g])
         );
      end
   endgenerate

   // Encode the one-hot position
   always_comb begin
      pos_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (pos[i]) begin
            pos_idx = pos_idx | CW'(i);
         end
      end
   end

   // Result and next count
   always_comb begin
      status_in = ste_pkg::ST_OK;
      index_in  = ste_pkg::INDEX_W'(count_ff);
      count_in  = count_ff;
      case (action)
         ste_pkg::ACT_FIND: begin
            if (found) begin
               index_in = ste_pkg::INDEX_W'(pos_idx);
            end else begin
               status_in = ste_pkg::ST_ABSENT;
            end
         end
         ste_pkg::ACT_INSERT: begin
            if (full) begin
               status_in = ste_pkg::ST_FULL;
            end else begin
               index_in = ste_pkg::INDEX_W'(pos_idx);
               count_in = count_ff + CW'(1);
            end
         end
         ste_pkg::ACT_ERASE: begin
            if (found) begin
               index_in = ste_pkg::INDEX_W'(pos_idx);
               count_in = count_ff - CW'(1);
            end else begin
               status_in = ste_pkg::ST_ABSENT;
            end
         end
         ste_pkg::ACT_CLEAR: begin
            index_in = '0;
            count_in = '0;
         end
         default: begin
            status_in = ste_pkg::ST_OK;
         end
      endcase
   end

   // Response register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_in;
         index_ff  <= index_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.index       = index_ff;
   assign rsp_ch.entry_count = ste_pkg::INDEX_W'(count_ff);

endmodule

// File: rtl/core/ste_checker.sv
// Port-level checker of the sorted table engine and its bind.
`include "sorted_table_engine_assert.svh"

module ste_checker #(
   parameter int DEPTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ste_pkg::STATUS_W-1:0]  rsp_status,
   input logic [ste_pkg::INDEX_W-1:0]   rsp_index,
   input logic [ste_pkg::INDEX_W-1:0]   rsp_entry_count
);

   localparam logic [ste_pkg::INDEX_W-1:0] FULL_COUNT = ste_pkg::INDEX_W'(DEPTH);

   // A stalled response keeps its transaction
   `STE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_index) && $stable(rsp_entry_count))

   // An empty response register never blocks a request
   `STE_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready)

   // A dropped insert reports a full table and its count as index
   `STE_ASSERT_NOW(a_full_report, rsp_valid && (rsp_status == ste_pkg::ST_FULL),
      (rsp_entry_count == FULL_COUNT) && (rsp_index == rsp_entry_count))

   // A miss reports the count as index
   `STE_ASSERT_NOW(a_absent_index, rsp_valid && (rsp_status == ste_pkg::ST_ABSENT),
      rsp_index == rsp_entry_count)

endmodule

bind sorted_table_engine ste_checker #(
   .DEPTH (DEPTH)
) u_ste_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_index       (rsp_ch.index),
   .rsp_entry_count (rsp_ch.entry_count)
);

// File: verif/sorted_table_engine_tb.sv
// Self-checking testbench for the sorted table engine: directed table, then random action mix.
module sorted_table_engine_tb;

   localparam int TABLE_DEPTH  = 16;
   localparam int NUM_DIRECTED = 24;
   localparam int NUM_PHASES   = 10;
   localparam int PHASE_ITEMS  = 100;

   typedef struct {
      logic [ste_pkg::STATUS_W-1:0] status;
      logic [ste_pkg::INDEX_W-1:0]  index;
      logic [ste_pkg::INDEX_W-1:0]  entry_count;
   } outcome_type;

   // One directed row: action, operand, repeat count, and a typed-in outcome if known
   typedef struct {
      ste_pkg::action_type                act;
      logic signed [ste_pkg::VALUE_W-1:0] value;
      int                                 reps;
      bit                                 typed;
      logic [ste_pkg::STATUS_W-1:0]       st;
      logic [ste_pkg::INDEX_W-1:0]        idx;
      logic [ste_pkg::INDEX_W-1:0]        cnt;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ste_req_if req_ch ();
   ste_rsp_if rsp_ch ();

   sorted_table_engine #(.DEPTH(TABLE_DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predictor state: mirror of the sorted table
   logic signed [ste_pkg::VALUE_W-1:0] table_vals [TABLE_DEPTH];
   int                                 table_count = 0;

   outcome_type pending_outcomes [$];
   int          error_count     = 0;
   int          action_seen [4] = '{0, 0, 0, 0};
   int          match_count     = 0;
   int          full_drop_count = 0;
   int          max_fill        = 0;
   bit          send_eager      = 1'b0;
   bit          rsp_eager       = 1'b0;

   // Directed cases: empty table, extremes, duplicates, misses, full table, clear
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{ste_pkg::ACT_FIND,   32'sd0,         1,  1'b1, ste_pkg::ST_ABSENT, 5'd0,  5'd0},
      '{ste_pkg::ACT_ERASE,  32'sd5,         1,  1'b1, ste_pkg::ST_ABSENT, 5'd0,  5'd0},
      '{ste_pkg::ACT_CLEAR,  32'sd0,         1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd0},
      '{ste_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd1},
      '{ste_pkg::ACT_INSERT, 32'sh8000_0000, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd2},
      '{ste_pkg::ACT_INSERT, 32'sd0,         1,  1'b1, ste_pkg::ST_OK,     5'd1,  5'd3},
      '{ste_pkg::ACT_INSERT, 32'sd0,         1,  1'b1, ste_pkg::ST_OK,     5'd1,  5'd4},
      '{ste_pkg::ACT_FIND,   32'sd0,         1,  1'b1, ste_pkg::ST_OK,     5'd1,  5'd4},
      '{ste_pkg::ACT_FIND,   32'sh7FFF_FFFF, 1,  1'b1, ste_pkg::ST_OK,     5'd3,  5'd4},
      '{ste_pkg::ACT_FIND,   32'shFFFF_FFFF, 1,  1'b1, ste_pkg::ST_ABSENT, 5'd4,  5'd4},
      '{ste_pkg::ACT_ERASE,  32'sd0,         1,  1'b1, ste_pkg::ST_OK,     5'd1,  5'd3},
      '{ste_pkg::ACT_ERASE,  32'sh8000_0000, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd2},
      '{ste_pkg::ACT_INSERT, 32'shFFFF_FFFF, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd3},
      '{ste_pkg::ACT_ERASE,  32'sh7FFF_FFFF, 1,  1'b1, ste_pkg::ST_OK,     5'd2,  5'd2},
      '{ste_pkg::ACT_CLEAR,  32'shFFFF_FFFF, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd0},
      '{ste_pkg::ACT_INSERT, 32'sh5555_5555, 16, 1'b0, ste_pkg::ST_OK,     5'd0,  5'd0},
      '{ste_pkg::ACT_INSERT, 32'sd1,         1,  1'b1, ste_pkg::ST_FULL,   5'd16, 5'd16},
      '{ste_pkg::ACT_INSERT, 32'sh8000_0000, 1,  1'b1, ste_pkg::ST_FULL,   5'd16, 5'd16},
      '{ste_pkg::ACT_FIND,   32'sh5555_5555, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd16},
      '{ste_pkg::ACT_ERASE,  32'sh5555_5555, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd15},
      '{ste_pkg::ACT_INSERT, 32'sh8000_0000, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd16},
      '{ste_pkg::ACT_ERASE,  32'sh2AAA_AAAA, 1,  1'b1, ste_pkg::ST_ABSENT, 5'd16, 5'd16},
      '{ste_pkg::ACT_FIND,   32'sh7FFF_FFFF, 1,  1'b1, ste_pkg::ST_ABSENT, 5'd16, 5'd16},
      '{ste_pkg::ACT_CLEAR,  32'shAAAA_AAAA, 1,  1'b1, ste_pkg::ST_OK,     5'd0,  5'd0}
   };

   // Clock: period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one action to the mirrored table and return the outcome it should produce
   function automatic outcome_type apply_action(ste_pkg::action_type act,
                                                logic signed [ste_pkg::VALUE_W-1:0] val);
      outcome_type res;
      int          pos;
      pos = 0;
      while (pos < table_count && table_vals[pos] < val) pos++;
      res.status = ste_pkg::ST_OK;
      res.index  = '0;
      action_seen[act]++;
      case (act)
         ste_pkg::ACT_FIND: begin
            if (pos < table_count && table_vals[pos] == val) begin
               res.index = ste_pkg::INDEX_W'(pos);
               match_count++;
            end else begin
               res.status = ste_pkg::ST_ABSENT;
               res.index  = ste_pkg::INDEX_W'(table_count);
            end
         end
         ste_pkg::ACT_INSERT: begin
            if (table_count >= TABLE_DEPTH) begin
               res.status = ste_pkg::ST_FULL;
               res.index  = ste_pkg::INDEX_W'(table_count);
               full_drop_count++;
            end else begin
               for (int k = table_count; k > pos; k--) table_vals[k] = table_vals[k-1];
               table_vals[pos] = val;
               table_count++;
               res.index = ste_pkg::INDEX_W'(pos);
            end
         end
         ste_pkg::ACT_ERASE: begin
            if (pos < table_count && table_vals[pos] == val) begin
               for (int k = pos; k < table_count - 1; k++) table_vals[k] = table_vals[k+1];
               table_count--;
               res.index = ste_pkg::INDEX_W'(pos);
               match_count++;
            end else begin
               res.status = ste_pkg::ST_ABSENT;
               res.index  = ste_pkg::INDEX_W'(table_count);
            end
         end
         default: table_count = 0;
      endcase
      if (table_count > max_fill) max_fill = table_count;
      res.entry_count = ste_pkg::INDEX_W'(table_count);
      return res;
   endfunction

   // Drive one request after a random gap; record the expected outcome once accepted
   task automatic send_item(input ste_pkg::action_type act,
                            input logic signed [ste_pkg::VALUE_W-1:0] val,
                            input bit typed, input outcome_type want);
      int          gap;
      outcome_type predicted;
      if ($urandom_range(0, 31) == 0) send_eager = !send_eager;
      gap = send_eager ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.value  <= val;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready)) @(posedge clock);
      predicted = apply_action(act, val);
      pending_outcomes.push_back(typed ? want : predicted);
   endtask

   // Hold off the sender until every outstanding response has come back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Response side: random stalls, compare each accepted transaction with the oldest expectation
   initial begin
      int          stall;
      outcome_type want;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) rsp_eager = !rsp_eager;
         stall = rsp_eager ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding: status %0d index %0d count %0d",
                   rsp_ch.status, rsp_ch.index, rsp_ch.entry_count);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status mismatch: expected %0d, got %0d", want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.index !== want.index) begin
               $error("index mismatch: expected %0d, got %0d", want.index, rsp_ch.index);
               error_count++;
            end
            if (rsp_ch.entry_count !== want.entry_count) begin
               $error("entry_count mismatch: expected %0d, got %0d",
                      want.entry_count, rsp_ch.entry_count);
               error_count++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, then phases of random actions
   initial begin
      logic signed [ste_pkg::VALUE_W-1:0] value_pool [6];
      logic signed [ste_pkg::VALUE_W-1:0] val;
      ste_pkg::action_type                act;
      outcome_type                        no_want;
      bit                                 fill_phase;
      int                                 r;
      no_want      = '{ste_pkg::ST_OK, '0, '0};
      req_ch.valid  <= 1'b0;
      req_ch.action <= ste_pkg::ACT_FIND;
      req_ch.value  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps)
            send_item(directed_rows[i].act, directed_rows[i].value, directed_rows[i].typed,
                      '{directed_rows[i].st, directed_rows[i].idx, directed_rows[i].cnt});
      end
      drain_responses();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // Small value pool per phase so finds and erases hit and duplicates pile up
         foreach (value_pool[j]) begin
            case ($urandom_range(0, 7))
               0:       value_pool[j] = 32'sh8000_0000;
               1:       value_pool[j] = 32'sh7FFF_FFFF;
               2:       value_pool[j] = 32'sd0;
               3:       value_pool[j] = -32'sd1;
               default: value_pool[j] = $urandom;
            endcase
         end
         fill_phase = (ph % 2 == 0) || ($urandom_range(0, 1) == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (fill_phase)
               act = (r < 1)  ? ste_pkg::ACT_CLEAR :
                     (r < 70) ? ste_pkg::ACT_INSERT :
                     (r < 85) ? ste_pkg::ACT_FIND : ste_pkg::ACT_ERASE;
            else
               act = (r < 4)  ? ste_pkg::ACT_CLEAR :
                     (r < 35) ? ste_pkg::ACT_INSERT :
                     (r < 60) ? ste_pkg::ACT_FIND : ste_pkg::ACT_ERASE;
            if ($urandom_range(0, 4) == 0) val = $urandom;
            else val = value_pool[$urandom_range(0, 5)];
            send_item(act, val, 1'b0, no_want);
         end
         drain_responses();
      end

      // Let any stray response show up before the verdict
      repeat (8) @(posedge clock);
      $display("Covered %0d finds, %0d inserts, %0d erases, %0d clears; %0d hits on find/erase.",
               action_seen[ste_pkg::ACT_FIND], action_seen[ste_pkg::ACT_INSERT],
               action_seen[ste_pkg::ACT_ERASE], action_seen[ste_pkg::ACT_CLEAR], match_count);
      $display("Table peaked at %0d entries; %0d inserts were refused on a full table.",
               max_fill, full_drop_count);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("[sorted_table_engine] OK");
      end else begin
         $display("[sorted_table_engine] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("[sorted_table_engine] ERROR");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ste_pkg.sv
rtl/core/ste_if.sv
rtl/core/ste_cell.sv
rtl/core/sorted_table_engine.sv
rtl/core/ste_checker.sv
verif/sorted_table_engine_tb.sv
